[rtl/core/form_query_token_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Form query token decoder - assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef FORM_QUERY_TOKEN_DECODER_UNIT_DEFINES_SVH
`define FORM_QUERY_TOKEN_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define FQTD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fqtd: same-cycle check failed");

// next-cycle implication
`define FQTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fqtd: next-cycle check failed");

`endif

[rtl/core/fqtd_pkg.sv]
// ----------------------------------------------------------------------------
// Form query token decoder package
// Character codes, escape phase codes, terminator codes and the result type.
// ----------------------------------------------------------------------------
package fqtd_pkg;

  // special characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;

  // escape phase codes (code 3 behaves as idle)
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // token terminator codes
  localparam logic [1:0] TERM_EQUAL = 2'd0;
  localparam logic [1:0] TERM_AMP   = 2'd1;
  localparam logic [1:0] TERM_HASH  = 2'd2;
  localparam logic [1:0] TERM_NUL   = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_end;
    logic [1:0] terminator;
    logic       string_end;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // hex digit decode; ok is low for any non-digit
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.value = c[3:0];
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      h.value = 4'(c[3:0] + 4'd9);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic result_t make_byte(input logic [7:0] b);
    result_t r;
    r.out_byte   = b;
    r.token_end  = 1'b0;
    r.terminator = TERM_EQUAL;
    r.string_end = 1'b0;
    return r;
  endfunction

  function automatic result_t make_end(input logic [1:0] term, input logic send);
    result_t r;
    r.out_byte   = 8'd0;
    r.token_end  = 1'b1;
    r.terminator = term;
    r.string_end = send;
    return r;
  endfunction

endpackage

[rtl/core/fqtd_in_if.sv]
// ----------------------------------------------------------------------------
// Form query token decoder input channel
// Valid/ready channel carrying one raw query byte and its string start flag.
// ----------------------------------------------------------------------------
interface fqtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;

  modport source (output valid, output in_byte, output string_start, input ready);
  modport sink   (input valid, input in_byte, input string_start, output ready);
endinterface

[rtl/core/fqtd_out_if.sv]
// ----------------------------------------------------------------------------
// Form query token decoder output channel
// Valid/ready channel carrying one decoded byte or one token end marker.
// ----------------------------------------------------------------------------
interface fqtd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_end;
  logic [1:0] terminator;
  logic       string_end;

  modport source (output valid, output out_byte, output token_end, output terminator,
                  output string_end, input ready);
  modport sink   (input valid, input out_byte, input token_end, input terminator,
                  input string_end, output ready);
endinterface

[rtl/core/form_query_token_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Form query token decoder
// Splits a form-encoded query byte stream into decoded name/value tokens.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the output is not stalled and gives at most
// one result per byte: a decoded byte, or a token end marker with its
// terminator ('=', '&', '#', NUL). An input transfer passes through one input
// register, then the decode logic and escape state update, then a result
// register backed by a one-entry skid buffer, so input transfers continue
// while the output is stalled until the skid buffer fills. Sustained rate is
// one byte per clock while the output is not stalled. '%' and the
// first escape byte give no result; bytes after '#' or NUL are dropped until
// the next transfer with string_start set. A leading '$' with string_start
// set is skipped.
// ----------------------------------------------------------------------------
`include "form_query_token_decoder_unit_defines.svh"

module form_query_token_decoder_unit (
  input  logic clk_i,
  input  logic rst_ni,
  fqtd_in_if.sink    in_i,
  fqtd_out_if.source out_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       s1_fire;

  // escape state
  logic [1:0] phase_q, phase_d;
  logic [3:0] hi_nib_q, hi_nib_d;
  logic       hi_valid_q, hi_valid_d;
  logic       done_q, done_d;

  // result buffer
  logic                 out_valid_q;
  fqtd_pkg::result_t    out_q;
  logic                 skid_valid_q;
  fqtd_pkg::result_t    skid_q;

  // decode outputs
  logic              emit;
  fqtd_pkg::result_t res;
  fqtd_pkg::hex_t    hex;
  logic              pop;
  logic              push;

  // handshakes
  assign s1_fire    = s1_valid_q && !skid_valid_q;
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign pop        = out_valid_q && out_o.ready;
  assign push       = s1_fire && emit;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q  <= in_i.in_byte;
      s1_start_q <= in_i.string_start;
    end
  end

  // decode one byte against the escape state
  always_comb begin
    logic [1:0] ph;
    logic [3:0] nib;
    logic       nib_ok;
    logic       dn;
    ph     = s1_start_q ? fqtd_pkg::PH_IDLE : phase_q;
    nib    = s1_start_q ? 4'd0 : hi_nib_q;
    nib_ok = s1_start_q ? 1'b0 : hi_valid_q;
    dn     = s1_start_q ? 1'b0 : done_q;
    hex    = fqtd_pkg::hex_decode(s1_byte_q);

    phase_d    = ph;
    hi_nib_d   = nib;
    hi_valid_d = nib_ok;
    done_d     = dn;
    emit       = 1'b0;
    res        = fqtd_pkg::make_byte(s1_byte_q);

    if (s1_start_q && s1_byte_q == fqtd_pkg::CH_DOLLAR) begin
      // leading dollar skipped, state already cleared
      emit = 1'b0;
    end else if (dn) begin
      // string over, drop
      emit = 1'b0;
    end else if (ph == fqtd_pkg::PH_FIRST || ph == fqtd_pkg::PH_SECOND) begin
      if (s1_byte_q == fqtd_pkg::CH_NUL) begin
        // nul inside an escape ends the string
        phase_d    = fqtd_pkg::PH_IDLE;
        hi_nib_d   = 4'd0;
        hi_valid_d = 1'b0;
        done_d     = 1'b1;
        emit       = 1'b1;
        res        = fqtd_pkg::make_end(fqtd_pkg::TERM_NUL, 1'b1);
      end else if (ph == fqtd_pkg::PH_FIRST) begin
        phase_d    = fqtd_pkg::PH_SECOND;
        hi_nib_d   = hex.ok ? hex.value : 4'd0;
        hi_valid_d = hex.ok;
      end else begin
        // second escape byte, prefix rule
        phase_d    = fqtd_pkg::PH_IDLE;
        hi_nib_d   = 4'd0;
        hi_valid_d = 1'b0;
        emit       = 1'b1;
        if (!nib_ok) begin
          res = fqtd_pkg::make_byte(8'd0);
        end else if (hex.ok) begin
          res = fqtd_pkg::make_byte({nib, hex.value});
        end else begin
          res = fqtd_pkg::make_byte({4'd0, nib});
        end
      end
    end else begin
      phase_d = fqtd_pkg::PH_IDLE;
      emit    = 1'b1;
      case (s1_byte_q)
        fqtd_pkg::CH_EQUAL: res = fqtd_pkg::make_end(fqtd_pkg::TERM_EQUAL, 1'b0);
        fqtd_pkg::CH_AMP:   res = fqtd_pkg::make_end(fqtd_pkg::TERM_AMP, 1'b0);
        fqtd_pkg::CH_HASH: begin
          done_d = 1'b1;
          res    = fqtd_pkg::make_end(fqtd_pkg::TERM_HASH, 1'b1);
        end
        fqtd_pkg::CH_NUL: begin
          done_d = 1'b1;
          res    = fqtd_pkg::make_end(fqtd_pkg::TERM_NUL, 1'b1);
        end
        fqtd_pkg::CH_PLUS:  res = fqtd_pkg::make_byte(fqtd_pkg::CH_SPACE);
        fqtd_pkg::CH_PERCENT: begin
          emit       = 1'b0;
          phase_d    = fqtd_pkg::PH_FIRST;
          hi_nib_d   = 4'd0;
          hi_valid_d = 1'b0;
        end
        default:            res = fqtd_pkg::make_byte(s1_byte_q);
      endcase
    end
  end

  // escape state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= fqtd_pkg::PH_IDLE;
      hi_nib_q   <= 4'd0;
      hi_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else if (s1_fire) begin
      phase_q    <= phase_d;
      hi_nib_q   <= hi_nib_d;
      hi_valid_q <= hi_valid_d;
      done_q     <= done_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // output drive
  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.token_end  = out_q.token_end;
  assign out_o.terminator = out_q.terminator;
  assign out_o.string_end = out_q.string_end;

  // checks
  `FQTD_ASSERT_IMPL(a_skid_needs_head, skid_valid_q, out_valid_q)
  `FQTD_ASSERT_IMPL(a_done_not_escaping, done_q, phase_q == fqtd_pkg::PH_IDLE)
  `FQTD_ASSERT_IMPL(a_nibble_only_second, hi_valid_q, phase_q == fqtd_pkg::PH_SECOND)
  `FQTD_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_q && !out_o.ready, skid_valid_q)

endmodule
